/* design/fpt2a_pkg.sv */
// Shared types, constants and digit helpers for the temperature text converter.
`timescale 1ns / 1ps
`default_nettype none
package fpt2a_pkg;

    localparam int FPT2A_QUEUE_DEPTH = 2;

    localparam logic signed [15:0] ERR_CODE_RESET = 16'sh8000;
    localparam logic signed [15:0] TEMP_MIN       = -16'sd2048;
    localparam logic signed [15:0] TEMP_MAX       = 16'sd2047;
    localparam logic [7:0]         HUNDRED        = 8'd100;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_R     = 8'h72;

    typedef struct packed {
        logic       err;
        logic       neg;
        logic       hund;
        logic       tens_on;
        logic [3:0] tens;
        logic [3:0] ones;
        logic [3:0] frac;
    } fpt2a_item_t;

    // sixteenths to tenths, truncated
    function automatic logic [3:0] frac_digit(input logic [3:0] sixteenths);
        logic [3:0] d;
        unique case (sixteenths)
            4'd0, 4'd1:   d = 4'd0;
            4'd2, 4'd3:   d = 4'd1;
            4'd4:         d = 4'd2;
            4'd5, 4'd6:   d = 4'd3;
            4'd7:         d = 4'd4;
            4'd8, 4'd9:   d = 4'd5;
            4'd10, 4'd11: d = 4'd6;
            4'd12:        d = 4'd7;
            4'd13, 4'd14: d = 4'd8;
            default:      d = 4'd9;
        endcase
        return d;
    endfunction

    // quotient by ten for values below one hundred
    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

endpackage
`default_nettype wire

/* design/fpt2a_front.sv */
// Front end: error register, input handshake and classification into digits.
`timescale 1ns / 1ps
`default_nettype none
module fpt2a_front
    import fpt2a_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic signed [15:0] cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_temperature,
    input  wire logic               q_full,
    output logic                    q_push,
    output fpt2a_item_t             q_item
);

    logic signed [15:0] err_code_reg;
    logic signed [11:0] sat;
    logic [11:0]        mag;
    logic [7:0]         whole;
    logic [6:0]         rem;
    logic [3:0]         tens;
    logic [7:0]         tens_x10;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign q_push    = s_valid && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_code_reg <= ERR_CODE_RESET;
        end else if (cfg_valid) begin
            err_code_reg <= cfg_data;
        end
    end

    always_comb begin
        priority if (s_temperature < TEMP_MIN) begin
            sat = TEMP_MIN[11:0];
        end else if (s_temperature > TEMP_MAX) begin
            sat = TEMP_MAX[11:0];
        end else begin
            sat = s_temperature[11:0];
        end
        mag      = sat[11] ? 12'(-sat) : 12'(sat);
        whole    = mag[11:4];
        rem      = (whole >= HUNDRED) ? 7'(whole - HUNDRED) : whole[6:0];
        tens     = div10(rem);
        tens_x10 = {tens, 3'b000} + {3'b000, tens, 1'b0};

        q_item.err     = (s_temperature == err_code_reg);
        q_item.neg     = sat[11];
        q_item.hund    = (whole >= HUNDRED);
        q_item.tens_on = (whole >= HUNDRED) || (tens != 4'd0);
        q_item.tens    = tens;
        q_item.ones    = 4'({1'b0, rem} - tens_x10);
        q_item.frac    = frac_digit(mag[3:0]);
    end

endmodule
`default_nettype wire

/* design/fpt2a_queue.sv */
// Short queue of classified words between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module fpt2a_queue
    import fpt2a_pkg::*;
#(
    parameter int DEPTH = FPT2A_QUEUE_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire fpt2a_item_t  push_item,
    output logic              full,
    input  wire logic         pop,
    output logic              not_empty,
    output fpt2a_item_t       head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    fpt2a_item_t   mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

/* design/fpt2a_back.sv */
// Back end: character sequencer with registered output word.
`timescale 1ns / 1ps
`default_nettype none
module fpt2a_back
    import fpt2a_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_not_empty,
    input  wire fpt2a_item_t q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_is_last
);

    typedef enum logic [3:0] {
        P_SIGN, P_HUND, P_TENS, P_ONES, P_DOT, P_FRAC, P_NUL,
        P_E, P_R1, P_R2, P_EDOT
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_step;
    phase_t      phase_first;
    logic        busy_reg;
    logic        m_valid_reg;
    logic [7:0]  char_reg;
    logic        last_reg;
    fpt2a_item_t cur_reg;
    logic [7:0]  char_now;
    logic        adv;
    logic        load;

    assign m_valid    = m_valid_reg;
    assign m_out_char = char_reg;
    assign m_is_last  = last_reg;

    assign adv   = !m_valid_reg || m_ready;
    assign load  = adv && q_not_empty && (!busy_reg || phase_reg == P_NUL);
    assign q_pop = load;

    always_comb begin
        priority if (q_head.err) begin
            phase_first = P_E;
        end else if (q_head.neg) begin
            phase_first = P_SIGN;
        end else if (q_head.hund) begin
            phase_first = P_HUND;
        end else if (q_head.tens_on) begin
            phase_first = P_TENS;
        end else begin
            phase_first = P_ONES;
        end
    end

    always_comb begin
        unique case (phase_reg)
            P_SIGN:  phase_step = cur_reg.hund ? P_HUND :
                                  (cur_reg.tens_on ? P_TENS : P_ONES);
            P_HUND:  phase_step = P_TENS;
            P_TENS:  phase_step = P_ONES;
            P_ONES:  phase_step = P_DOT;
            P_DOT:   phase_step = P_FRAC;
            P_FRAC:  phase_step = P_NUL;
            P_E:     phase_step = P_R1;
            P_R1:    phase_step = P_R2;
            P_R2:    phase_step = P_EDOT;
            P_EDOT:  phase_step = P_NUL;
            default: phase_step = P_NUL;
        endcase
    end

    always_comb begin
        unique case (phase_reg)
            P_SIGN:        char_now = CH_MINUS;
            P_HUND:        char_now = CH_ZERO + 8'd1;
            P_TENS:        char_now = CH_ZERO + {4'd0, cur_reg.tens};
            P_ONES:        char_now = CH_ZERO + {4'd0, cur_reg.ones};
            P_DOT, P_EDOT: char_now = CH_DOT;
            P_FRAC:        char_now = CH_ZERO + {4'd0, cur_reg.frac};
            P_E:           char_now = CH_E;
            P_R1, P_R2:    char_now = CH_R;
            default:       char_now = CH_NUL;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            phase_reg   <= P_NUL;
        end else if (adv) begin
            m_valid_reg <= busy_reg;
            if (busy_reg) begin
                char_reg <= char_now;
                last_reg <= (phase_reg == P_NUL);
            end
            if (load) begin
                cur_reg   <= q_head;
                phase_reg <= phase_first;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                phase_reg <= phase_step;
                busy_reg  <= (phase_reg != P_NUL);
            end
        end
    end

endmodule
`default_nettype wire

/* design/fixed_point_temp_to_ascii.sv */
// Top level: signed Q12.4 temperature to decimal ASCII text converter.
//
//  channel | ports                              | word
//  --------+------------------------------------+----------------------------------
//  cfg     | cfg_valid cfg_ready cfg_data       | error code sentinel, 16 bits signed
//  s       | s_valid s_ready s_temperature      | one reading, 16 bits signed
//  m       | m_valid m_ready m_out_char m_is_last | one character, NUL marked last
//
//  Each reading leaves as 4 to 7 characters from the back-end sequencer, one per
//  cycle while m_ready is high. Back-to-back readings chain without a gap; when
//  idle, a reading passes the queue and phase register to the output register. The
//  queue holds QUEUE_DEPTH readings, so input is taken while the output stalls
//  until it fills. Synchronous active-low reset; the error code resets to -32768.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_temp_to_ascii
    import fpt2a_pkg::*;
#(
    parameter int QUEUE_DEPTH = FPT2A_QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic signed [15:0] cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_temperature,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_out_char,
    output logic                    m_is_last
);

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_not_empty;
    fpt2a_item_t q_in;
    fpt2a_item_t q_head;

    fpt2a_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_temperature (s_temperature),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    fpt2a_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    fpt2a_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_is_last   (m_is_last)
    );

endmodule
`default_nettype wire
